// ----- rtl/core/sorted_unique_key_table_defines.svh -----
// assertion macros for the sorted key table
`ifndef SORTED_UNIQUE_KEY_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_KEY_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds at every rising clock edge out of reset
`define SUKT_CHECK(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sorted key table check failed");
// consequent holds in the cycle after the antecedent
`define SUKT_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key table sequence check failed");
`else
`define SUKT_CHECK(label, expr)
`define SUKT_CHECK_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/sukt_pkg.sv -----
package sukt_pkg;

    // default table depth
    localparam int CAPACITY_DEFAULT = 64;

    // command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;

    // status codes
    localparam logic [2:0] STAT_DONE     = 3'd0;
    localparam logic [2:0] STAT_DUP      = 3'd1;
    localparam logic [2:0] STAT_RANGE    = 3'd2;
    localparam logic [2:0] STAT_NOTFOUND = 3'd3;
    localparam logic [2:0] STAT_FULL     = 3'd4;

    // command word
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] chapter;
        logic [15:0] page;
        logic [15:0] pages_in_chapter;
        logic [5:0]  position;
    } cmd_word_t;

    // response word
    typedef struct packed {
        logic [2:0] status;
        logic [5:0] slot;
        logic [6:0] count;
    } rsp_word_t;

    // one stored entry
    typedef struct packed {
        logic [15:0] chapter;
        logic [15:0] page;
        logic [15:0] pages_in_chapter;
    } entry_t;

endpackage

// ----- rtl/core/sorted_unique_key_table.sv -----
// sorted table of (chapter, page) keys with a page-count payload, held in one ram
// find and add scan up to the first key not below the target; add then shifts the
// later entries up one slot and writes the new one, remove shifts those after pos down
// throughput: one word at a time, set by the single read port walking the entries
// a new word is taken while the previous response still waits in the output register
// reset: entry count cleared at once, ram contents left as is, no clearing pass
`include "sorted_unique_key_table_defines.svh"

module sorted_unique_key_table #(
    parameter int CAPACITY = sukt_pkg::CAPACITY_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  sukt_pkg::cmd_word_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output sukt_pkg::rsp_word_t rsp
);
    import sukt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 6) ? CW : 6;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   total_reg, total_next;
    cmd_word_t       item_reg, item_next;
    logic [CW-1:0]   scan_idx_reg, scan_idx_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]   at_reg, at_next;
    logic [AW-1:0]   src_reg, src_next;
    logic [AW-1:0]   dst_reg, dst_next;
    logic [CW-1:0]   left_reg, left_next;
    logic            shift_up_reg, shift_up_next;
    logic [2:0]      status_reg, status_next;
    logic [5:0]      slot_reg, slot_next;
    rsp_word_t       out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    // ram access
    logic            mem_we;
    logic [AW-1:0]   wr_addr;
    entry_t          wr_data;
    logic            mem_re;
    logic [AW-1:0]   rd_addr;
    entry_t          rd_data;

    // scan helpers
    logic [31:0]     key;
    logic [31:0]     rkey;
    logic            stop;
    logic            hit;
    logic [AW-1:0]   stop_at;
    logic [PW-1:0]   pos_ext;
    logic [PW-1:0]   total_ext;

    // response register loads this cycle
    logic            rsp_load;

    sukt_entry_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (mem_re),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cmd_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign key       = {item_reg.chapter, item_reg.page};
    assign rkey      = {rd_data.chapter, rd_data.page};
    assign pos_ext   = PW'(cmd.position);
    assign total_ext = PW'(total_reg);
    assign rsp_load  = (state_reg == ST_RESP) && (!out_valid_reg || rsp_ready);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        item_next      = item_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = pend_reg;
        cmp_idx_next   = cmp_idx_reg;
        at_next        = at_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        left_next      = left_reg;
        shift_up_next  = shift_up_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        mem_re         = 1'b0;
        rd_addr        = '0;
        stop           = 1'b0;
        hit            = 1'b0;
        stop_at        = '0;

        // response leaves when taken
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next = cmd;
                    pend_next = 1'b0;
                    unique case (cmd.command) inside
                        CMD_ADD, CMD_FIND:
                        begin
                            scan_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                        CMD_REMOVE:
                        begin
                            if (pos_ext < total_ext)
                            begin
                                src_next      = AW'(pos_ext + PW'(1));
                                left_next     = total_reg - CW'(1) - CW'(pos_ext);
                                shift_up_next = 1'b0;
                                status_next   = STAT_DONE;
                                slot_next     = cmd.position;
                                state_next    = ST_SHIFT;
                            end
                            else
                            begin
                                status_next = STAT_RANGE;
                                slot_next   = '0;
                                state_next  = ST_RESP;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_RANGE;
                            slot_next   = '0;
                            state_next  = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // table is sorted: stop at the first key not below the target
                if (pend_reg && (rkey >= key))
                begin
                    stop    = 1'b1;
                    hit     = (rkey == key);
                    stop_at = cmp_idx_reg;
                end
                else if (!pend_reg && (scan_idx_reg == total_reg))
                begin
                    stop    = 1'b1;
                    stop_at = AW'(total_reg);
                end

                if (stop)
                begin
                    pend_next = 1'b0;
                    if (item_reg.command == CMD_ADD)
                    begin
                        if (hit)
                        begin
                            status_next = STAT_DUP;
                            slot_next   = 6'(stop_at);
                            state_next  = ST_RESP;
                        end
                        else if (total_reg == CW'(CAPACITY))
                        begin
                            status_next = STAT_FULL;
                            slot_next   = '0;
                            state_next  = ST_RESP;
                        end
                        else
                        begin
                            at_next       = stop_at;
                            src_next      = AW'(total_reg - CW'(1));
                            left_next     = total_reg - CW'(stop_at);
                            shift_up_next = 1'b1;
                            status_next   = STAT_DONE;
                            slot_next     = 6'(stop_at);
                            state_next    = ST_SHIFT;
                        end
                    end
                    else
                    begin
                        status_next = hit ? STAT_DONE : STAT_NOTFOUND;
                        slot_next   = hit ? 6'(stop_at) : 6'd0;
                        state_next  = ST_RESP;
                    end
                end
                else if (scan_idx_reg < total_reg)
                begin
                    mem_re        = 1'b1;
                    rd_addr       = AW'(scan_idx_reg);
                    pend_next     = 1'b1;
                    cmp_idx_next  = AW'(scan_idx_reg);
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            ST_SHIFT:
            begin
                // write back the entry read last cycle, one slot over
                if (pend_reg)
                begin
                    mem_we  = 1'b1;
                    wr_addr = dst_reg;
                    wr_data = rd_data;
                end
                if (left_reg != '0)
                begin
                    mem_re    = 1'b1;
                    rd_addr   = src_reg;
                    pend_next = 1'b1;
                    dst_next  = shift_up_reg ? src_reg + AW'(1) : src_reg - AW'(1);
                    src_next  = shift_up_reg ? src_reg - AW'(1) : src_reg + AW'(1);
                    left_next = left_reg - CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (shift_up_reg)
                        begin
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            total_next = total_reg - CW'(1);
                            state_next = ST_RESP;
                        end
                    end
                end
            end

            ST_WRITE:
            begin
                // new entry into the opened slot
                mem_we                   = 1'b1;
                wr_addr                  = at_reg;
                wr_data.chapter          = item_reg.chapter;
                wr_data.page             = item_reg.page;
                wr_data.pages_in_chapter = item_reg.pages_in_chapter;
                total_next               = total_reg + CW'(1);
                state_next               = ST_RESP;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next.status = status_reg;
                    out_next.slot   = slot_reg;
                    out_next.count  = 7'(total_reg);
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        at_reg       <= at_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        left_reg     <= left_next;
        shift_up_reg <= shift_up_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        out_reg      <= out_next;
    end

    // checks
    `SUKT_CHECK(a_total_bound, total_reg <= CW'(CAPACITY))
    `SUKT_CHECK(a_write_in_table, !mem_we || (CW'(wr_addr) <= total_reg))
    `SUKT_CHECK_NEXT(a_accept_busy, cmd_valid && cmd_ready, !cmd_ready)
    `SUKT_CHECK_NEXT(a_rsp_count, rsp_load, out_valid_reg && (out_reg.count == 7'(total_reg)))

endmodule

// ----- rtl/core/sukt_entry_ram.sv -----
module sukt_entry_ram #(
    parameter int DEPTH = sukt_pkg::CAPACITY_DEFAULT
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  sukt_pkg::entry_t           wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output sukt_pkg::entry_t           rd_data
);
    import sukt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds when idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
